// ===== rtl/core/mwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Millisecond wait timer bank package
// Shared constants, command and status codes, and the request type.
// ----------------------------------------------------------------------------
`default_nettype none

package mwt_pkg;

  localparam int TIMERS = 8;
  localparam int IDX_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_POLL   = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [1:0] ST_WAIT = 2'd0;
  localparam logic [1:0] ST_UP   = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [31:0] DUR_CANCEL = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  timer_id;
    logic [31:0] duration;
  } mwt_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/mwt_bank.sv =====
// ----------------------------------------------------------------------------
// Timer bank state and evaluation
// Holds the millisecond counter and the per-timer state, evaluates one item
// and updates the state when the item is processed.
// ----------------------------------------------------------------------------
`default_nettype none

module mwt_bank (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire mwt_pkg::mwt_req_t req,
  output logic [1:0]           status
);

  logic [31:0]                now_r;
  logic [31:0]                now_nxt;
  logic [mwt_pkg::TIMERS-1:0] wait_r;
  logic [mwt_pkg::TIMERS-1:0] wait_nxt;
  logic [31:0]                start_r [mwt_pkg::TIMERS];
  logic                       start_we;
  logic [mwt_pkg::IDX_W-1:0]  idx;
  logic                       id_ok;
  logic [31:0]                elapsed;

  assign idx     = req.timer_id[mwt_pkg::IDX_W-1:0];
  assign id_ok   = {1'b0, req.timer_id} < 9'(mwt_pkg::TIMERS);
  assign elapsed = now_r - start_r[idx];

  always_comb begin
    now_nxt  = now_r;
    wait_nxt = wait_r;
    start_we = 1'b0;
    status   = mwt_pkg::ST_WAIT;
    case (req.command)
      mwt_pkg::CMD_TICK: begin
        now_nxt = now_r + 32'd1;
      end
      mwt_pkg::CMD_POLL, mwt_pkg::CMD_CANCEL: begin
        if (!id_ok) begin
          status = mwt_pkg::ST_BAD;
        end else if (req.command == mwt_pkg::CMD_CANCEL ||
                     req.duration == mwt_pkg::DUR_CANCEL) begin
          wait_nxt[idx] = 1'b0;
        end else if (!wait_r[idx]) begin
          wait_nxt[idx] = 1'b1;
          start_we      = 1'b1;
        end else if (elapsed > req.duration) begin
          wait_nxt[idx] = 1'b0;
          status        = mwt_pkg::ST_UP;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      wait_r <= '0;
    end else if (fire) begin
      now_r  <= now_nxt;
      wait_r <= wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && start_we) begin
      start_r[idx] <= now_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/millisecond_wait_timer_bank.sv =====
// Each item goes through the input register, then the result register.
// Throughput: one item per cycle unless out_ready stalls, with the timer
// state read and updated in a single stage between those two registers.
// Reset: synchronous active-low rst_n clears the counter, all timers to idle,
// and both pipeline valid flags.
// ----------------------------------------------------------------------------
// Millisecond wait timer bank
// Bank of wait timers sharing one millisecond counter, advanced by tick
// items, with a valid/ready input channel and a registered status output.
// ----------------------------------------------------------------------------
`default_nettype none

module millisecond_wait_timer_bank (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_timer_id,
  input  wire logic [31:0] in_duration,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status
);

  logic              in_valid_r;
  mwt_pkg::mwt_req_t req_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic              advance;
  logic              fire;
  logic [1:0]        status;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  mwt_bank u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .req    (req_r),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.command  <= in_command;
      req_r.timer_id <= in_timer_id;
      req_r.duration <= in_duration;
    end
    if (fire) begin
      out_status_r <= status;
    end
  end

`ifndef ASSERT_OFF
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed item did not produce a result");

  a_tick_status: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && req_r.command == mwt_pkg::CMD_TICK) |=> out_status_r == mwt_pkg::ST_WAIT)
    else $error("tick item gave a nonzero status");

  a_bad_id: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (req_r.command == mwt_pkg::CMD_POLL || req_r.command == mwt_pkg::CMD_CANCEL)
     && {1'b0, req_r.timer_id} >= 9'(mwt_pkg::TIMERS))
    |=> out_status_r == mwt_pkg::ST_BAD)
    else $error("bad timer number not reported");

  a_empty_input_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input stalled with an empty input register");
`endif

endmodule

`default_nettype wire
